>>> sv/trss_pkg.sv
package trss_pkg;

   localparam int MAX_BINS    = 1024;
   localparam int SAMPLE_W    = 16;
   localparam int CFG_W       = 11;
   localparam int HALF_DEPTH  = MAX_BINS / 2 + 1;
   localparam int ADDR_W      = $clog2(HALF_DEPTH);
   localparam int BIN_W       = $clog2(HALF_DEPTH);
   localparam int POS_W       = $clog2(MAX_BINS);
   localparam int LEN_W       = $clog2(MAX_BINS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int MIN_BINS    = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // One classified result waiting for the arithmetic: a is the partner bin
   // (stored or current), b is the bin that just arrived.
   typedef struct packed {
      logic [BIN_W-1:0] bin_index;
      logic             frame_last;
      sample_type       a_re;
      sample_type       a_im;
      sample_type       b_re;
      sample_type       b_im;
   } op_type;

   // Queue status seen by the front end for its credit check.
   typedef struct packed {
      logic [QLVL_W-1:0] level;
      logic              push;
   } qstat_type;

endpackage

>>> sv/trss_ram.sv
module trss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 513
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/trss_front.sv
module trss_front
   import trss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CFG_W-1:0]  csr_wr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  sample_type        req_sample_re,
   input  sample_type        req_sample_im,
   input  logic [QLVL_W-1:0] q_level,
   output logic              push_valid,
   output op_type            push_op
);

   logic [CFG_W-1:0] bin_count_ff;
   logic [POS_W-1:0] pos_ff, pos_in;

   logic             s1_valid_ff;
   logic             s1_self_ff;
   logic             s1_last_ff;
   logic [BIN_W-1:0] s1_idx_ff;
   sample_type       s1_re_ff, s1_im_ff;

   logic [LEN_W-1:0] n_eff, half_n, ceil_half, j_ext, k_ext;
   logic [POS_W-1:0] j;
   logic             accept, store, emit, self_pair, last;
   logic [2*SAMPLE_W-1:0] rd_data;

   // Credit check: every slot held by stage 1 or the queue is reserved.
   assign req_ready = (QLVL_W'(q_level) + QLVL_W'(s1_valid_ff)) < QLVL_W'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (bin_count_ff < CFG_W'(MIN_BINS)) begin
         n_eff = LEN_W'(MIN_BINS);
      end else if (32'(bin_count_ff) > MAX_BINS) begin
         n_eff = LEN_W'(MAX_BINS);
      end else begin
         n_eff = LEN_W'(bin_count_ff);
      end
      half_n    = n_eff >> 1;
      ceil_half = LEN_W'((n_eff + LEN_W'(1)) >> 1);
      j         = (LEN_W'(pos_ff) >= n_eff) ? '0 : pos_ff;
      j_ext     = LEN_W'(j);
      store     = (j_ext <= half_n);
      emit      = (j == '0) || (j_ext >= ceil_half);
      k_ext     = (j == '0) ? '0 : n_eff - j_ext;
      self_pair = (k_ext == j_ext);
      last      = (j_ext == n_eff - LEN_W'(1));
      pos_in    = (j_ext + LEN_W'(1) >= n_eff) ? '0 : j + POS_W'(1);
   end

   trss_ram #(
      .WIDTH (2*SAMPLE_W),
      .DEPTH (HALF_DEPTH)
   ) u_held (
      .clock   (clock),
      .wr_en   (accept && store),
      .wr_addr (j[ADDR_W-1:0]),
      .wr_data ({req_sample_re, req_sample_im}),
      .rd_addr (k_ext[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= CFG_W'(MAX_BINS);
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= accept && emit;
         if (csr_wr_en) begin
            bin_count_ff <= csr_wr_data;
            pos_ff       <= '0;
         end else if (accept) begin
            pos_ff <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         s1_self_ff <= self_pair;
         s1_last_ff <= last;
         s1_idx_ff  <= k_ext[BIN_W-1:0];
         s1_re_ff   <= req_sample_re;
         s1_im_ff   <= req_sample_im;
      end
   end

   // Partner operand: the RAM word, or the bin itself at k = 0 and k = N/2.
   always_comb begin
      push_op.bin_index  = s1_idx_ff;
      push_op.frame_last = s1_last_ff;
      push_op.b_re       = s1_re_ff;
      push_op.b_im       = s1_im_ff;
      if (s1_self_ff) begin
         push_op.a_re = s1_re_ff;
         push_op.a_im = s1_im_ff;
      end else begin
         push_op.a_re = rd_data[2*SAMPLE_W-1:SAMPLE_W];
         push_op.a_im = rd_data[SAMPLE_W-1:0];
      end
   end

   assign push_valid = s1_valid_ff;

endmodule

>>> sv/trss_queue.sv
module trss_queue
   import trss_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  op_type    push_op,
   output logic      pop_valid,
   input  logic      pop_ready,
   output op_type    pop_op,
   output qstat_type status
);

   op_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QLVL_W-1:0] level_ff, level_in;
   logic              pop;

   assign pop_valid = (level_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      level_in = level_ff;
      if (push_valid && !pop) begin
         level_in = level_ff + QLVL_W'(1);
      end else if (pop && !push_valid) begin
         level_in = level_ff - QLVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         level_ff <= level_in;
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign status.level = level_ff;
   assign status.push  = push_valid;

endmodule

>>> sv/trss_back.sv
module trss_back
   import trss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   output logic             op_ready,
   input  op_type           op,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [BIN_W-1:0] rsp_bin_index,
   output sample_type       rsp_even_re,
   output sample_type       rsp_even_im,
   output sample_type       rsp_odd_re,
   output sample_type       rsp_odd_im,
   output logic             rsp_frame_last
);

   logic                    valid_ff;
   logic [BIN_W-1:0]        idx_ff;
   logic                    last_ff;
   sample_type              even_re_ff, even_im_ff, odd_re_ff, odd_im_ff;
   logic signed [SAMPLE_W:0] s_even_re, s_even_im, s_odd_re, s_odd_im;
   logic                    take;

   // One bit of growth, then drop the LSB: floor of half, never overflows.
   always_comb begin
      s_even_re = {op.a_re[SAMPLE_W-1], op.a_re} + {op.b_re[SAMPLE_W-1], op.b_re};
      s_even_im = {op.a_im[SAMPLE_W-1], op.a_im} - {op.b_im[SAMPLE_W-1], op.b_im};
      s_odd_re  = {op.a_im[SAMPLE_W-1], op.a_im} + {op.b_im[SAMPLE_W-1], op.b_im};
      s_odd_im  = {op.b_re[SAMPLE_W-1], op.b_re} - {op.a_re[SAMPLE_W-1], op.a_re};
   end

   assign op_ready = !valid_ff || rsp_ready;
   assign take     = op_valid && op_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (op_ready) begin
         valid_ff <= op_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         idx_ff     <= op.bin_index;
         last_ff    <= op.frame_last;
         even_re_ff <= s_even_re[SAMPLE_W:1];
         even_im_ff <= s_even_im[SAMPLE_W:1];
         odd_re_ff  <= s_odd_re[SAMPLE_W:1];
         odd_im_ff  <= s_odd_im[SAMPLE_W:1];
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_bin_index  = idx_ff;
   assign rsp_frame_last = last_ff;
   assign rsp_even_re    = even_re_ff;
   assign rsp_even_im    = even_im_ff;
   assign rsp_odd_re     = odd_re_ff;
   assign rsp_odd_im     = odd_im_ff;

endmodule

>>> sv/two_real_spectra_split.sv
// Two-for-one real FFT split. Feed the N complex bins of one FFT of two real
// signals (packed as real and imaginary parts) in index order 0..N-1, one
// transfer per bin; N comes from csr_wr_data (clamped to 2..1024) and any
// write restarts the frame at index 0. Results come out as bins 0..N/2 of
// the two separate spectra: bin 0 on input index 0, then bin N-j on input
// index j for j from ceil(N/2) to N-1, so the output order is 0, then
// descending from N/2 down to 1, with rsp_frame_last on bin 1. Each value is
// the floor of half a 17-bit sum or difference. Throughput is one bin per
// clock while req_ready is high: the front end writes inputs 0..N/2 into a
// single-port-write, single-port-read 513x32 RAM and reads the partner
// bin in the same cycle. An input transfer reaches its result through the
// RAM read register, the 4-entry queue and the output register. The queue
// lets the input side keep flowing while rsp_ready is low until the queue
// and the front-end stage register hold four results; then req_ready drops.
module two_real_spectra_split
   import trss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  sample_type       req_sample_re,
   input  sample_type       req_sample_im,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [BIN_W-1:0] rsp_bin_index,
   output sample_type       rsp_even_re,
   output sample_type       rsp_even_im,
   output sample_type       rsp_odd_re,
   output sample_type       rsp_odd_im,
   output logic             rsp_frame_last
);

   // front end -> queue
   logic      push_valid;
   op_type    push_op;
   // queue -> back end
   logic      pop_valid, pop_ready;
   op_type    pop_op;
   qstat_type q_stat;

   // Front: position counter, classify, RAM write/read, operand select.
   trss_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_re (req_sample_re),
      .req_sample_im (req_sample_im),
      .q_level       (q_stat.level),
      .push_valid    (push_valid),
      .push_op       (push_op)
   );

   // Short queue decoupling the front from output backpressure.
   trss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op),
      .status     (q_stat)
   );

   // Back: half sums/differences into the output register.
   trss_back u_back (
      .clock          (clock),
      .reset          (reset),
      .op_valid       (pop_valid),
      .op_ready       (pop_ready),
      .op             (pop_op),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bin_index  (rsp_bin_index),
      .rsp_even_re    (rsp_even_re),
      .rsp_even_im    (rsp_even_im),
      .rsp_odd_re     (rsp_odd_re),
      .rsp_odd_im     (rsp_odd_im),
      .rsp_frame_last (rsp_frame_last)
   );

   // Credit scheme: an arriving push always finds a free queue slot.
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_stat.push |-> (q_stat.level < QLVL_W'(QUEUE_DEPTH)))
      else $error("queue push with no free slot");

   // Input side only stalls when results are backed up inside the block.
   a_ready_low_has_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> ((q_stat.level != '0) || q_stat.push))
      else $error("req_ready low with empty queue");

   // The last result of a frame always comes from input N-1, i.e. bin 1.
   a_last_is_bin_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_last) |-> (rsp_bin_index == BIN_W'(1)))
      else $error("frame_last on a bin other than 1");

endmodule
